[design/etl_pkg.sv]
// Package for the expression token lexer.
// Holds token kinds, scan modes, character codes, result structs and class helpers.
// No dependencies.
`default_nettype none

package etl_pkg;

  // Fixed widths of the result fields
  localparam int unsigned START_W = 24;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned POS_W   = 16;

  // Defaults for the top-level parameters
  localparam int unsigned INDEX_BITS_DEF    = 24;
  localparam int unsigned POSITION_BITS_DEF = 16;

  // Result queue depth (power of two, at least 2)
  localparam int unsigned OQ_DEPTH = 4;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  typedef enum logic [3:0] {
    TK_IDENT  = 4'd0,
    TK_INT    = 4'd1,
    TK_STR    = 4'd2,
    TK_LPAREN = 4'd3,
    TK_RPAREN = 4'd4,
    TK_LT     = 4'd5,
    TK_GT     = 4'd6,
    TK_LE     = 4'd7,
    TK_GE     = 4'd8,
    TK_EQ     = 4'd9,
    TK_NE     = 4'd10,
    TK_AND    = 4'd11,
    TK_OR     = 4'd12,
    TK_NOT    = 4'd13,
    TK_ERROR  = 4'd14,
    TK_EOF    = 4'd15
  } tok_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_STRING = 3'd3,
    MODE_ESC    = 3'd4,
    MODE_SYMBOL = 3'd5
  } scan_mode_e;

  typedef enum logic [2:0] {
    SYM_LT  = 3'd0,
    SYM_GT  = 3'd1,
    SYM_EQ  = 3'd2,
    SYM_NOT = 3'd3,
    SYM_AMP = 3'd4,
    SYM_BAR = 3'd5
  } sym_e;

  typedef struct packed {
    tok_kind_e            kind;
    logic [START_W-1:0]   start;
    logic [LEN_W-1:0]     len;
    logic [POS_W-1:0]     line;
    logic [POS_W-1:0]     col;
    logic                 last;
  } tok_t;

  // Results of one step: up to two tokens, first one first
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIG0) && (c <= CH_DIG9);
  endfunction

  function automatic logic is_alpha_start(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
           (c == CH_USCORE);
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_alpha_start(c) || is_digit(c) || (c == CH_DOT);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
  endfunction

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Operator kind when the second byte is '='
  function automatic tok_kind_e with_eq_kind(input sym_e s);
    tok_kind_e k;
    unique case (s)
      SYM_LT:  k = TK_LE;
      SYM_GT:  k = TK_GE;
      SYM_EQ:  k = TK_EQ;
      SYM_NOT: k = TK_NE;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

  // Operator kind when the operator stands alone
  function automatic tok_kind_e alone_kind(input sym_e s);
    tok_kind_e k;
    unique case (s)
      SYM_LT:  k = TK_LT;
      SYM_GT:  k = TK_GT;
      SYM_NOT: k = TK_NOT;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[design/etl_scan.sv]
// Lexer state and single-step scan logic: consumes one byte, yields 0..2 tokens.
// Depends on etl_pkg.
`default_nettype none

module etl_scan #(
  parameter int unsigned INDEX_BITS    = etl_pkg::INDEX_BITS_DEF,
  parameter int unsigned POSITION_BITS = etl_pkg::POSITION_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    char_code_i,
  input  wire logic          take_i,
  output etl_pkg::step_t     step_o
);
  import etl_pkg::*;

  localparam int unsigned IW = INDEX_BITS;
  localparam int unsigned PW = POSITION_BITS;

  // State
  scan_mode_e          mode_q, mode_d;
  sym_e                sym_q, sym_d;
  logic [IW-1:0]       start_q, start_d;
  logic [LEN_W-1:0]    count_q, count_d;
  logic [PW-1:0]       tline_q, tline_d;
  logic [PW-1:0]       tcol_q, tcol_d;
  logic [PW-1:0]       line_q, line_d;
  logic [PW-1:0]       col_q, col_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic                ended_q, ended_d;

  // Step scratch
  logic [PW-1:0]       pl, pc;
  logic                again;
  logic                emit_a, emit_b;
  tok_kind_e           kind_a, kind_b;
  logic [LEN_W-1:0]    len_a, len_b;
  logic [IW-1:0]       start_b;
  logic [PW-1:0]       line_b, col_b;
  tok_t                tok_a, tok_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      sym_q   <= SYM_LT;
      start_q <= '0;
      count_q <= '0;
      tline_q <= '0;
      tcol_q  <= '0;
      line_q  <= '0;
      col_q   <= '0;
      idx_q   <= '0;
      ended_q <= 1'b0;
    end else if (take_i) begin
      mode_q  <= mode_d;
      sym_q   <= sym_d;
      start_q <= start_d;
      count_q <= count_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      line_q  <= line_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
      ended_q <= ended_d;
    end
  end

  // Position after this byte
  always_comb begin
    if (char_code_i == CH_LF) begin
      pl = line_q + 1'b1;
      pc = '0;
    end else begin
      pl = line_q;
      pc = col_q + 1'b1;
    end
  end

  // Scan step: slot A closes the held token, slot B is idle rescan or post-end eof
  always_comb begin
    mode_d  = mode_q;
    sym_d   = sym_q;
    start_d = start_q;
    count_d = count_q;
    tline_d = tline_q;
    tcol_d  = tcol_q;
    line_d  = line_q;
    col_d   = col_q;
    idx_d   = idx_q;
    ended_d = ended_q;
    again   = 1'b0;
    emit_a  = 1'b0;
    kind_a  = TK_ERROR;
    len_a   = '0;
    emit_b  = 1'b0;
    kind_b  = TK_EOF;
    len_b   = '0;
    start_b = idx_q;
    line_b  = pl;
    col_b   = pc;

    if (ended_q) begin
      // after end of text every byte gives the same eof
      emit_b = 1'b1;
      line_b = line_q;
      col_b  = col_q;
    end else begin
      line_d = pl;
      col_d  = pc;
      unique case (mode_q)
        MODE_IDENT, MODE_NUMBER: begin
          if ((mode_q == MODE_IDENT) ? is_ident_char(char_code_i)
                                     : is_digit(char_code_i)) begin
            count_d = sat_inc(count_q);
          end else begin
            emit_a = 1'b1;
            kind_a = (mode_q == MODE_IDENT) ? TK_IDENT : TK_INT;
            len_a  = count_q;
            mode_d = MODE_IDLE;
            again  = 1'b1;
          end
        end
        MODE_STRING, MODE_ESC: begin
          priority if (char_code_i == CH_NUL) begin
            // string left open at end of text
            emit_a = 1'b1;
            kind_a = TK_ERROR;
            len_a  = count_q;
            mode_d = MODE_IDLE;
            again  = 1'b1;
          end else if (mode_q == MODE_ESC) begin
            count_d = sat_inc(count_q);
            mode_d  = MODE_STRING;
          end else if (char_code_i == CH_QUOTE) begin
            emit_a = 1'b1;
            kind_a = TK_STR;
            len_a  = count_q;
            mode_d = MODE_IDLE;
          end else begin
            count_d = sat_inc(count_q);
            if (char_code_i == CH_BSLASH) begin
              mode_d = MODE_ESC;
            end
          end
        end
        MODE_SYMBOL: begin
          mode_d = MODE_IDLE;
          emit_a = 1'b1;
          priority if (char_code_i == CH_EQ) begin
            kind_a = with_eq_kind(sym_q);
            len_a  = LEN_W'(2);
          end else if ((char_code_i == CH_AMP) && (sym_q == SYM_AMP)) begin
            kind_a = TK_AND;
            len_a  = LEN_W'(2);
          end else if ((char_code_i == CH_BAR) && (sym_q == SYM_BAR)) begin
            kind_a = TK_OR;
            len_a  = LEN_W'(2);
          end else begin
            kind_a = alone_kind(sym_q);
            len_a  = LEN_W'(1);
            again  = 1'b1;
          end
        end
        default: begin
          // idle, and the unused mode codes
          mode_d = MODE_IDLE;
          again  = 1'b1;
        end
      endcase

      // idle scan of the byte
      if (again) begin
        priority if (char_code_i == CH_NUL) begin
          ended_d = 1'b1;
          emit_b  = 1'b1;
          kind_b  = TK_EOF;
        end else if (is_blank(char_code_i)) begin
          mode_d = MODE_IDLE;
        end else begin
          start_d = idx_q;
          tline_d = pl;
          tcol_d  = pc;
          count_d = LEN_W'(1);
          priority if (is_alpha_start(char_code_i)) begin
            mode_d = MODE_IDENT;
          end else if (is_digit(char_code_i)) begin
            mode_d = MODE_NUMBER;
          end else if (char_code_i == CH_QUOTE) begin
            mode_d  = MODE_STRING;
            start_d = idx_q + 1'b1;
            count_d = '0;
          end else if (char_code_i == CH_LPAR) begin
            emit_b = 1'b1;
            kind_b = TK_LPAREN;
            len_b  = LEN_W'(1);
          end else if (char_code_i == CH_RPAR) begin
            emit_b = 1'b1;
            kind_b = TK_RPAREN;
            len_b  = LEN_W'(1);
          end else if (char_code_i == CH_LT) begin
            sym_d  = SYM_LT;
            mode_d = MODE_SYMBOL;
          end else if (char_code_i == CH_GT) begin
            sym_d  = SYM_GT;
            mode_d = MODE_SYMBOL;
          end else if (char_code_i == CH_EQ) begin
            sym_d  = SYM_EQ;
            mode_d = MODE_SYMBOL;
          end else if (char_code_i == CH_BANG) begin
            sym_d  = SYM_NOT;
            mode_d = MODE_SYMBOL;
          end else if (char_code_i == CH_AMP) begin
            sym_d  = SYM_AMP;
            mode_d = MODE_SYMBOL;
          end else if (char_code_i == CH_BAR) begin
            sym_d  = SYM_BAR;
            mode_d = MODE_SYMBOL;
          end else begin
            emit_b = 1'b1;
            kind_b = TK_ERROR;
            len_b  = LEN_W'(1);
          end
        end
      end

      if (!ended_d) begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  // Assemble the tokens of this step
  always_comb begin
    tok_a.kind  = kind_a;
    tok_a.start = START_W'(start_q);
    tok_a.len   = len_a;
    tok_a.line  = POS_W'(tline_q);
    tok_a.col   = POS_W'(tcol_q);
    tok_a.last  = ~emit_b;

    tok_b.kind  = kind_b;
    tok_b.start = START_W'(start_b);
    tok_b.len   = len_b;
    tok_b.line  = POS_W'(line_b);
    tok_b.col   = POS_W'(col_b);
    tok_b.last  = 1'b1;

    step_o.count  = {1'b0, emit_a} + {1'b0, emit_b};
    step_o.first  = emit_a ? tok_a : tok_b;
    step_o.second = tok_b;
  end

endmodule

`default_nettype wire

[design/etl_outq.sv]
// Small result queue: takes up to two tokens a cycle, hands out one a cycle.
// Depends on etl_pkg.
`default_nettype none

module etl_outq #(
  parameter int unsigned DEPTH = etl_pkg::OQ_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire etl_pkg::step_t               push_i,
  input  wire logic                         pop_i,
  output etl_pkg::tok_t                     head_o,
  output logic [$clog2(DEPTH+1)-1:0]        level_o
);
  import etl_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);

  tok_t               entries_q [DEPTH];
  logic [PTR_W-1:0]   wp_q, wp_d;
  logic [PTR_W-1:0]   rp_q, rp_d;
  logic [LVL_W-1:0]   level_q, level_d;
  logic [PTR_W-1:0]   wp_next;

  assign wp_next = wp_q + 1'b1;

  // Pointer and fill level update
  always_comb begin
    wp_d    = wp_q + PTR_W'(push_i.count);
    rp_d    = rp_q + PTR_W'(pop_i);
    level_d = level_q + LVL_W'(push_i.count) - LVL_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      level_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      level_q <= level_d;
    end
  end

  // Token storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entries_q[wp_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      entries_q[wp_next] <= push_i.second;
    end
  end

  assign head_o  = entries_q[rp_q];
  assign level_o = level_q;

endmodule

`default_nettype wire

[design/expression_token_lexer_unit.sv]
// Expression token lexer: one text byte per transaction in, one token per transaction out.
// The tokens of an accepted byte are queued and offered from the queue head in order.
// One byte per cycle when not stalled; a byte's two tokens leave one after the other.
// The input stalls while the result queue holds fewer than two free entries.
// Reset (asynchronous, active low) returns the scanner to idle at line 0, column 0,
// index 0, and empties the result queue.
`default_nettype none

module expression_token_lexer_unit #(
  parameter int unsigned INDEX_BITS    = etl_pkg::INDEX_BITS_DEF,
  parameter int unsigned POSITION_BITS = etl_pkg::POSITION_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // byte channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    char_code_i,
  // token channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [3:0]                         token_kind_o,
  output logic [etl_pkg::START_W-1:0]        start_index_o,
  output logic [etl_pkg::LEN_W-1:0]          token_length_o,
  output logic [etl_pkg::POS_W-1:0]          line_number_o,
  output logic [etl_pkg::POS_W-1:0]          column_number_o,
  output logic                               last_of_run_o
);
  import etl_pkg::*;

  localparam int unsigned LVL_W = $clog2(OQ_DEPTH + 1);

  logic              in_take;
  logic              out_take;
  step_t             step;
  step_t             push;
  tok_t              head;
  logic [LVL_W-1:0]  level;

  // Handshakes
  assign in_stall_o  = (level > LVL_W'(OQ_DEPTH - 2));
  assign in_take     = in_valid_i & ~in_stall_o;
  assign out_valid_o = (level != '0);
  assign out_take    = out_valid_o & ~out_stall_i;

  etl_scan #(
    .INDEX_BITS    (INDEX_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (char_code_i),
    .take_i      (in_take),
    .step_o      (step)
  );

  // Only push tokens of an accepted byte
  always_comb begin
    push = step;
    if (!in_take) begin
      push.count = 2'd0;
    end
  end

  etl_outq #(
    .DEPTH (OQ_DEPTH)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_take),
    .head_o  (head),
    .level_o (level)
  );

  // Result fields
  assign token_kind_o    = head.kind;
  assign start_index_o   = head.start;
  assign token_length_o  = head.len;
  assign line_number_o   = head.line;
  assign column_number_o = head.col;
  assign last_of_run_o   = head.last;

`ifndef SYNTHESIS
  // Queue never overfills
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LVL_W'(OQ_DEPTH))
    else $error("result queue level above depth");

  // Level rises by at most two tokens per cycle
  a_level_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (level <= $past(level) + 2))
    else $error("result queue level jumped");

  // End of text is always the closing token of its byte
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (token_kind_o == TK_EOF)) |-> last_of_run_o)
    else $error("eof token not marked last");

  // A stalled token stays on the output unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(token_kind_o) &&
      $stable(start_index_o) && $stable(token_length_o) && $stable(line_number_o) &&
      $stable(column_number_o) && $stable(last_of_run_o)))
    else $error("stalled token changed");
`endif

endmodule

`default_nettype wire

[bench/expression_token_lexer_unit_tb.sv]
// Testbench for expression_token_lexer_unit: drives text bytes, predicts the tokens,
// and checks every token transaction field by field against the prediction.
// Depends on etl_pkg and the expression_token_lexer_unit RTL.
`timescale 1ns / 100ps

module expression_token_lexer_unit_tb;
  import etl_pkg::*;

  localparam int IDLE_PCT   = 24;
  localparam int STALL_LIMIT = 3000;
  localparam int RAND_BYTES = 340;
  localparam int LONG_RUN   = 48;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          char_code_i = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [3:0]          token_kind_o;
  logic [START_W-1:0]  start_index_o;
  logic [LEN_W-1:0]    token_length_o;
  logic [POS_W-1:0]    line_number_o;
  logic [POS_W-1:0]    column_number_o;
  logic                last_of_run_o;

  expression_token_lexer_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .start_index_o  (start_index_o),
    .token_length_o (token_length_o),
    .line_number_o  (line_number_o),
    .column_number_o(column_number_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shared bench state
  tok_t expected_tokens[$];
  tok_t want;
  int   errors = 0;
  int   quiet_cycles = 0;
  logic calm = 1'b0;
  int   bytes_sent = 0;

  // Lexer state mirrored by the predictor
  scan_mode_e         mode = MODE_IDLE;
  sym_e               pend_sym = SYM_LT;
  logic [START_W-1:0] tok_start = '0;
  logic [LEN_W-1:0]   tok_len = '0;
  logic [POS_W-1:0]   tok_line = '0;
  logic [POS_W-1:0]   tok_col = '0;
  logic [POS_W-1:0]   cur_line = '0;
  logic [POS_W-1:0]   cur_col = '0;
  logic [START_W-1:0] next_index = '0;
  logic               text_done = 1'b0;

  // Character classes
  function automatic logic digit_ch(input logic [7:0] c);
    return c >= CH_DIG0 && c <= CH_DIG9;
  endfunction

  function automatic logic word_head(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           c == CH_USCORE;
  endfunction

  function automatic logic word_tail(input logic [7:0] c);
    return word_head(c) || digit_ch(c) || c == CH_DOT;
  endfunction

  function automatic logic space_ch(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic [LEN_W-1:0] len_plus1(input logic [LEN_W-1:0] v);
    return (v == {LEN_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic tok_t make_tok(input tok_kind_e k, input logic [START_W-1:0] s,
                                    input logic [LEN_W-1:0] l, input logic [POS_W-1:0] ln,
                                    input logic [POS_W-1:0] cl);
    tok_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.line  = ln;
    t.col   = cl;
    t.last  = 1'b0;
    return t;
  endfunction

  // Predict the tokens that one accepted byte yields and queue them
  task automatic lex_byte(input logic [7:0] c);
    tok_t               res[2];
    int                 n;
    logic               rescan;
    tok_kind_e          k;
    logic [POS_W-1:0]   nl;
    logic [POS_W-1:0]   nc;
    logic [START_W-1:0] idx;
    n = 0;
    rescan = 1'b0;
    idx = next_index;
    if (text_done) begin
      res[0] = make_tok(TK_EOF, idx, '0, cur_line, cur_col);
      n = 1;
    end else begin
      if (c == CH_LF) begin
        nl = cur_line + 1'b1;
        nc = '0;
      end else begin
        nl = cur_line;
        nc = cur_col + 1'b1;
      end
      case (mode)
        MODE_IDENT, MODE_NUMBER: begin
          if (mode == MODE_IDENT ? word_tail(c) : digit_ch(c)) begin
            tok_len = len_plus1(tok_len);
          end else begin
            k = (mode == MODE_IDENT) ? TK_IDENT : TK_INT;
            res[n] = make_tok(k, tok_start, tok_len, tok_line, tok_col);
            n++;
            mode = MODE_IDLE;
            rescan = 1'b1;
          end
        end
        MODE_STRING, MODE_ESC: begin
          if (c == CH_NUL) begin
            // string still open when the text ends
            res[n] = make_tok(TK_ERROR, tok_start, tok_len, tok_line, tok_col);
            n++;
            mode = MODE_IDLE;
            rescan = 1'b1;
          end else if (mode == MODE_ESC) begin
            tok_len = len_plus1(tok_len);
            mode = MODE_STRING;
          end else if (c == CH_QUOTE) begin
            res[n] = make_tok(TK_STR, tok_start, tok_len, tok_line, tok_col);
            n++;
            mode = MODE_IDLE;
          end else begin
            tok_len = len_plus1(tok_len);
            if (c == CH_BSLASH) mode = MODE_ESC;
          end
        end
        MODE_SYMBOL: begin
          mode = MODE_IDLE;
          if (c == CH_EQ) begin
            case (pend_sym)
              SYM_LT:  k = TK_LE;
              SYM_GT:  k = TK_GE;
              SYM_EQ:  k = TK_EQ;
              SYM_NOT: k = TK_NE;
              default: k = TK_ERROR;
            endcase
            res[n] = make_tok(k, tok_start, LEN_W'(2), tok_line, tok_col);
            n++;
          end else if (c == CH_AMP && pend_sym == SYM_AMP) begin
            res[n] = make_tok(TK_AND, tok_start, LEN_W'(2), tok_line, tok_col);
            n++;
          end else if (c == CH_BAR && pend_sym == SYM_BAR) begin
            res[n] = make_tok(TK_OR, tok_start, LEN_W'(2), tok_line, tok_col);
            n++;
          end else begin
            // single-byte operator; a lone '=', '&' or '|' is an error
            case (pend_sym)
              SYM_LT:  k = TK_LT;
              SYM_GT:  k = TK_GT;
              SYM_NOT: k = TK_NOT;
              default: k = TK_ERROR;
            endcase
            res[n] = make_tok(k, tok_start, LEN_W'(1), tok_line, tok_col);
            n++;
            rescan = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase

      // Byte seen from idle: may start a token or yield one directly
      if (rescan) begin
        if (c == CH_NUL) begin
          text_done = 1'b1;
          res[n] = make_tok(TK_EOF, idx, '0, nl, nc);
          n++;
        end else if (!space_ch(c)) begin
          tok_start = idx;
          tok_line = nl;
          tok_col = nc;
          tok_len = LEN_W'(1);
          if (word_head(c)) begin
            mode = MODE_IDENT;
          end else if (digit_ch(c)) begin
            mode = MODE_NUMBER;
          end else if (c == CH_QUOTE) begin
            mode = MODE_STRING;
            tok_start = idx + 1'b1;
            tok_len = '0;
          end else if (c == CH_LPAR) begin
            res[n] = make_tok(TK_LPAREN, tok_start, LEN_W'(1), tok_line, tok_col);
            n++;
          end else if (c == CH_RPAR) begin
            res[n] = make_tok(TK_RPAREN, tok_start, LEN_W'(1), tok_line, tok_col);
            n++;
          end else begin
            mode = MODE_SYMBOL;
            case (c)
              CH_LT:   pend_sym = SYM_LT;
              CH_GT:   pend_sym = SYM_GT;
              CH_EQ:   pend_sym = SYM_EQ;
              CH_BANG: pend_sym = SYM_NOT;
              CH_AMP:  pend_sym = SYM_AMP;
              CH_BAR:  pend_sym = SYM_BAR;
              default: begin
                mode = MODE_IDLE;
                res[n] = make_tok(TK_ERROR, tok_start, LEN_W'(1), tok_line, tok_col);
                n++;
              end
            endcase
          end
        end
      end
      cur_line = nl;
      cur_col = nc;
      if (!text_done) next_index = idx + 1'b1;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_tokens.push_back(res[i]);
  endtask

  // Send one byte transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] c);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    lex_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold the input off until every predicted token has come out
  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  // All kinds but error and eof, adjacent tokens that force a second scan of a byte
  task automatic test_token_kinds();
    send_text("x.1(9)\"\\\"\"<=>=!===&&||<>!_\n");
  endtask

  // Lone '=', '&' and '|', '&=' and '|=', invalid bytes, blanks
  task automatic test_error_tokens();
    send_text("= &=|=|#");
    send_byte(8'hFF);
    send_text("\t&\r");
  endtask

  // A long string sent with no idling on either side
  task automatic test_long_string();
    calm = 1'b1;
    send_byte(CH_QUOTE);
    for (int i = 0; i < LONG_RUN; i++) send_byte(CH_LO_A + 8'(i % 26));
    send_byte(CH_QUOTE);
    send_text("zz 7\n");
    calm = 1'b0;
  endtask

  function automatic logic [7:0] rand_tail_ch();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return CH_LO_A + 8'(r);
    if (r < 52) return CH_UP_A + 8'(r - 26);
    if (r < 62) return CH_DIG0 + 8'(r - 52);
    return (r == 62) ? CH_USCORE : CH_DOT;
  endfunction

  // Random well-formed tokens with some noise mixed in
  task automatic send_random_piece();
    int          r;
    int          n;
    logic [7:0]  c;
    string       ops[14];
    ops = '{"<", ">", "<=", ">=", "==", "!=", "&&", "||", "!", "=", "&", "|", "&=", "|="};
    r = $urandom_range(0, 99);
    if (r < 25) begin
      do c = rand_tail_ch(); while (!word_head(c));
      send_byte(c);
      n = $urandom_range(0, 6);
      repeat (n) send_byte(rand_tail_ch());
    end else if (r < 40) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(CH_DIG0 + 8'($urandom_range(0, 9)));
    end else if (r < 52) begin
      send_byte(CH_QUOTE);
      n = $urandom_range(0, 8);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) begin
          send_byte(CH_BSLASH);
          send_byte(8'($urandom_range(1, 255)));
        end else begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
          send_byte(c);
        end
      end
      send_byte(CH_QUOTE);
    end else if (r < 75) begin
      send_text(ops[$urandom_range(0, 13)]);
    end else if (r < 82) begin
      send_byte($urandom_range(0, 1) ? CH_LPAR : CH_RPAR);
    end else if (r < 92) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: send_byte(CH_SPACE);
          1: send_byte(CH_TAB);
          2: send_byte(CH_CR);
          default: send_byte(CH_LF);
        endcase
      end
    end else begin
      send_byte(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_random_text();
    int base;
    base = bytes_sent;
    while (bytes_sent - base < RAND_BYTES) begin
      send_random_piece();
      if (bytes_sent - base > RAND_BYTES / 2 && bytes_sent - base < RAND_BYTES / 2 + 10)
        drain_tokens();
    end
    send_byte(CH_SPACE);
  endtask

  // String open at the end of text, then bytes after the end
  task automatic test_end_of_text();
    send_text("\"a\\");
    send_byte(CH_NUL);
    send_byte(8'h41);
    send_byte(CH_NUL);
    send_byte(8'hFF);
    send_byte(CH_QUOTE);
    send_byte(8'h80);
  endtask

  // Output side stalls at random, except during calm stretches
  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Compare every token transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        $error("token with none expected: kind %0d start %0d", token_kind_o, start_index_o);
        errors++;
      end else begin
        want = expected_tokens.pop_front();
        if (token_kind_o !== want.kind) begin
          $error("token_kind expected %0d got %0d", want.kind, token_kind_o);
          errors++;
        end
        if (start_index_o !== want.start) begin
          $error("start_index expected %0d got %0d", want.start, start_index_o);
          errors++;
        end
        if (token_length_o !== want.len) begin
          $error("token_length expected %0d got %0d", want.len, token_length_o);
          errors++;
        end
        if (line_number_o !== want.line) begin
          $error("line_number expected %0d got %0d", want.line, line_number_o);
          errors++;
        end
        if (column_number_o !== want.col) begin
          $error("column_number expected %0d got %0d", want.col, column_number_o);
          errors++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run expected %0d got %0d", want.last, last_of_run_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_token_kinds();
    test_error_tokens();
    test_long_string();
    test_random_text();
    test_end_of_text();

    drain_tokens();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
